>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define BXAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define BXAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bxavg_pkg.sv
// ----------------------------------------------------------------------------
// bxavg_pkg
// Sizes, scaling constants and shared types of the boxcar joint angle filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bxavg_pkg;

  // Block dimensions
  localparam int unsigned WINDOW_LEN  = 50;
  localparam int unsigned SAMPLE_BITS = 11;
  localparam int unsigned JOINTS      = 3;
  localparam int unsigned OUT_BITS    = 16;
  localparam int unsigned CFG_COUNT   = 6;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned ADDR_W      = $clog2(4 * CFG_COUNT);
  localparam int unsigned CFG_IDX_W   = ADDR_W - 2;

  // Window bookkeeping
  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned ROW_W  = JOINTS * SAMPLE_BITS;

  // Running sum holds WINDOW_LEN signed samples
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned MAG_W = SUM_W;

  // Scaling: angle = round(sum * round(pi * 2^28) / (660 * WINDOW_LEN * 2^15)).
  // 11 divides both 660 and round(pi * 2^28), so it is taken out of both.
  // The quotient is a multiply by a rounded-up reciprocal and a right shift;
  // FRAC_T is large enough that the error never crosses a rounding boundary
  // for any sum magnitude up to WINDOW_LEN * 2^(SAMPLE_BITS-1).
  localparam longint unsigned PI_Q28_DIV11 = 64'd76664987;
  localparam longint unsigned DEN_RED      = 64'd60 * WINDOW_LEN;
  localparam int unsigned FRAC_T = $clog2(120 * WINDOW_LEN * WINDOW_LEN) + SAMPLE_BITS - 1;
  localparam int unsigned SHIFT  = FRAC_T + 15;
  localparam logic [127:0] RECIP =
      ((128'(PI_Q28_DIV11) << FRAC_T) + 128'(DEN_RED) - 128'd1) / 128'(DEN_RED);
  localparam int unsigned RECIP_W = $clog2(RECIP + 128'd1);
  localparam int unsigned LO_W    = (RECIP_W + 1) / 2;
  localparam int unsigned HI_W    = RECIP_W - LO_W;
  localparam logic [LO_W-1:0] RECIP_LO = LO_W'(RECIP);
  localparam logic [HI_W-1:0] RECIP_HI = HI_W'(RECIP >> LO_W);
  localparam int unsigned PROD_W = MAG_W + RECIP_W + 1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SHIFT - 1);
  localparam int unsigned Q_W =
      (PROD_W - SHIFT > OUT_BITS + 1) ? (PROD_W - SHIFT) : (OUT_BITS + 1);
  localparam logic [Q_W-1:0] POS_LIM = Q_W'(2 ** (OUT_BITS - 1) - 1);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(2 ** (OUT_BITS - 1));

  // Shared types
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_BITS-1:0]    angle_t;

  localparam angle_t ANGLE_MAX    = {1'b0, {(OUT_BITS - 1){1'b1}}};
  localparam angle_t ANGLE_MIN    = {1'b1, {(OUT_BITS - 1){1'b0}}};
  localparam angle_t LIM_RESET_HI = angle_t'(25736);
  localparam angle_t LIM_RESET_LO = angle_t'(-25736);

  // Stage advance strobes from the pipeline control to each lane
  typedef struct packed {
    logic en_sum;
    logic en_prod;
    logic en_out;
  } bxavg_ctrl_t;

endpackage

>>> design/bxavg_lane.sv
// ----------------------------------------------------------------------------
// bxavg_lane
// One joint: running boxcar sum, scaling to Q3.13 radians, saturate and clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bxavg_lane import bxavg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bxavg_ctrl_t ctrl_i,
  input  logic        first_i,
  input  logic        filling_i,
  input  sample_t     x_i,
  input  sample_t     prime_i,
  input  sample_t     rd_i,
  input  angle_t      lo_i,
  input  angle_t      hi_i,
  output angle_t      angle_o,
  output logic        clip_o
);

  typedef logic signed [SUM_W:0] wsum_t;

  sample_t                  oldest;
  wsum_t                    base_sum;
  wsum_t                    next_sum;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic                     neg_q;
  logic [MAG_W+LO_W-1:0]    pp_lo_q;
  logic [MAG_W+HI_W-1:0]    pp_hi_q;
  logic [PROD_W-1:0]        full;
  logic [Q_W-1:0]           quo;
  logic                     sat;
  angle_t                   sat_angle;
  angle_t                   res_d;
  logic                     clip_d;
  angle_t                   angle_q;
  logic                     clip_q;

  // Pick the sample leaving the window and update the running sum
  always_comb begin
    priority if (first_i) begin
      oldest = x_i;
    end else if (filling_i) begin
      oldest = prime_i;
    end else begin
      oldest = rd_i;
    end
    base_sum = first_i ? wsum_t'(x_i) * wsum_t'(WINDOW_LEN) : wsum_t'(sum_q);
    next_sum = base_sum + wsum_t'(x_i) - wsum_t'(oldest);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.en_sum) begin
      sum_q <= next_sum[SUM_W-1:0];
    end
  end

  // Split the magnitude by the reciprocal into two partial products
  always_comb begin
    neg = sum_q[SUM_W-1];
    mag = neg ? MAG_W'(-sum_q) : MAG_W'(sum_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_prod) begin
      neg_q   <= neg;
      pp_lo_q <= (MAG_W + LO_W)'(mag) * (MAG_W + LO_W)'(RECIP_LO);
      pp_hi_q <= (MAG_W + HI_W)'(mag) * (MAG_W + HI_W)'(RECIP_HI);
    end
  end

  // Join the partial products, round half away from zero, saturate, clip
  always_comb begin
    full = (PROD_W'(pp_hi_q) << LO_W) + PROD_W'(pp_lo_q) + ROUND_HALF;
    quo  = Q_W'(full >> SHIFT);
    sat  = neg_q ? (quo > NEG_LIM) : (quo > POS_LIM);
    if (sat) begin
      sat_angle = neg_q ? ANGLE_MIN : ANGLE_MAX;
    end else begin
      sat_angle = neg_q ? -angle_t'(quo[OUT_BITS-1:0]) : angle_t'(quo[OUT_BITS-1:0]);
    end
    priority if (sat_angle < lo_i) begin
      res_d  = lo_i;
      clip_d = 1'b1;
    end else if (sat_angle > hi_i) begin
      res_d  = hi_i;
      clip_d = 1'b1;
    end else begin
      res_d  = sat_angle;
      clip_d = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_out) begin
      angle_q <= res_d;
      clip_q  <= clip_d;
    end
  end

  assign angle_o = angle_q;
  assign clip_o  = clip_q;

  // The running sum never leaves the range of a full window of samples
  `BXAVG_ASSERT(a_sum_range, (MAG_W + 1)'(mag) <= (MAG_W + 1)'(WINDOW_LEN << (SAMPLE_BITS - 1)), "running sum out of range")

endmodule

>>> design/boxcar_average_to_joint_angle_top.sv
// ----------------------------------------------------------------------------
// boxcar_average_to_joint_angle_top
// Three stick channels through 50-tap boxcar averages to clipped joint angles.
// ----------------------------------------------------------------------------
// Takes one frame of three samples per cycle while in_ready_o is high and
// returns one result beat per frame, through four register stages: input
// register with the window memory read, running sum update, reciprocal
// partial products, then rounding, saturation and clipping into the output
// register. The window lives in one 50-row memory (one row per slot holding
// all three joints), read and written at the same slot on each accepted
// frame. No clearing pass follows reset: until a window has filled, the
// sample leaving it is the first frame's sample, so a row's read value is
// used only after the row has been written.
// The six clip limits sit on an APB port at byte addresses 0x00 to 0x14.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module boxcar_average_to_joint_angle_top import bxavg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Sample frames
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sample_t               stick_a_i,
  input  sample_t               stick_b_i,
  input  sample_t               stick_c_i,
  // Joint angles
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output angle_t                angle_a_o,
  output angle_t                angle_b_o,
  output angle_t                angle_c_o,
  output logic [JOINTS-1:0]     clipped_mask_o
);

  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  angle_t               lim_q [CFG_COUNT];

  sample_t              stick [JOINTS];
  logic [ROW_W-1:0]     wr_row;
  logic [ROW_W-1:0]     rd_q;
  logic [ROW_W-1:0]     win_mem [WINDOW_LEN];

  logic [SLOT_W-1:0]    slot_q;
  logic [FILL_W-1:0]    fill_q;
  logic                 primed_q;
  logic                 filling;
  sample_t              prime_q [JOINTS];
  sample_t              x_s1_q [JOINTS];
  logic                 first_s1_q;
  logic                 fill_s1_q;

  logic                 v1_q, v2_q, v3_q, vo_q;
  logic                 t_out, t3, t2, t1;
  logic                 acc, m1, m2, m3;
  bxavg_ctrl_t          ctrl;
  angle_t               angle [JOINTS];
  logic [JOINTS-1:0]    clip;

  // Configuration registers
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        lim_q[i] <= i[0] ? LIM_RESET_HI : LIM_RESET_LO;
      end
    end else if (cfg_wr && (cfg_idx < CFG_IDX_W'(CFG_COUNT))) begin
      lim_q[cfg_idx] <= pwdata[OUT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx < CFG_IDX_W'(CFG_COUNT)) begin
      prdata = APB_DATA_W'(lim_q[cfg_idx]);
    end
  end

  // Gather the frame into one memory row
  assign stick[0] = stick_a_i;
  assign stick[1] = stick_b_i;
  assign stick[2] = stick_c_i;

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      wr_row[j*SAMPLE_BITS +: SAMPLE_BITS] = stick[j];
    end
  end

  // Pipeline handshake: a stage loads when empty or when it drains this cycle
  assign t_out      = !vo_q || out_ready_i;
  assign t3         = !v3_q || t_out;
  assign t2         = !v2_q || t3;
  assign t1         = !v1_q || t2;
  assign in_ready_o = t1;
  assign acc        = in_valid_i && t1;
  assign m1         = v1_q && t2;
  assign m2         = v2_q && t3;
  assign m3         = v3_q && t_out;

  assign ctrl.en_sum  = m1;
  assign ctrl.en_prod = m2;
  assign ctrl.en_out  = m3;

  assign filling = fill_q < FILL_W'(WINDOW_LEN);

  // Hold valid flags, window position and the priming sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      vo_q     <= 1'b0;
      slot_q   <= '0;
      fill_q   <= '0;
      primed_q <= 1'b0;
      for (int j = 0; j < JOINTS; j++) begin
        prime_q[j] <= '0;
      end
    end else begin
      v1_q <= acc || (v1_q && !t2);
      v2_q <= m1 || (v2_q && !t3);
      v3_q <= m2 || (v3_q && !t_out);
      vo_q <= m3 || (vo_q && !out_ready_i);
      if (acc) begin
        slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
        if (filling) begin
          fill_q <= fill_q + 1'b1;
        end
        if (!primed_q) begin
          primed_q <= 1'b1;
          prime_q  <= stick;
        end
      end
    end
  end

  // Window memory: read the leaving row and write the new one at the same slot
  always_ff @(posedge clk_i) begin
    if (acc) begin
      win_mem[slot_q] <= wr_row;
      rd_q            <= win_mem[slot_q];
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_s1_q     <= stick;
      first_s1_q <= !primed_q;
      fill_s1_q  <= filling;
    end
  end

  // One datapath lane per joint
  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    bxavg_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .first_i   (first_s1_q),
      .filling_i (fill_s1_q),
      .x_i       (x_s1_q[j]),
      .prime_i   (prime_q[j]),
      .rd_i      (rd_q[j*SAMPLE_BITS +: SAMPLE_BITS]),
      .lo_i      (lim_q[2*j]),
      .hi_i      (lim_q[2*j+1]),
      .angle_o   (angle[j]),
      .clip_o    (clip[j])
    );
  end

  assign out_valid_o    = vo_q;
  assign angle_a_o      = angle[0];
  assign angle_b_o      = angle[1];
  assign angle_c_o      = angle[2];
  assign clipped_mask_o = clip;

  `BXAVG_ASSERT(a_fill_bound, fill_q <= FILL_W'(WINDOW_LEN), "fill count beyond window length")
  `BXAVG_ASSERT(a_slot_bound, {1'b0, slot_q} < (SLOT_W + 1)'(WINDOW_LEN), "write slot beyond window")
  `BXAVG_ASSERT(a_prime_first, (fill_q == '0) || primed_q, "window filling before priming")
  `BXAVG_ASSERT_NEXT(a_result_kept, v3_q && !vo_q, vo_q, "finished frame lost before output")

endmodule
